/* design/m3i_pkg.sv */
// Shared widths, lane counts and the divider pipeline payload type for the 3x3 inverse.
package m3i_pkg;

   localparam int LANES     = 9;
   localparam int DIV_STEPS = 32;
   localparam int ELEM_W    = 32;
   localparam int COF_W     = 65;
   localparam int CMAG_W    = 64;
   localparam int DET_W     = 97;
   localparam int DMAG_W    = 96;

   localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

   // One item in flight through the restoring divider stages.
   typedef struct packed {
      logic [LANES-1:0][DET_W-1:0]  rem;
      logic [LANES-1:0][ELEM_W-1:0] quo;
      logic [LANES-1:0]             neg;
      logic [LANES-1:0]             ovf;
      logic [DMAG_W-1:0]            dmag;
      logic                         zero;
   } div_type;

endpackage

/* design/m3i_div_stage.sv */
// One registered quotient-bit step of the nine parallel restoring dividers.
module m3i_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             i_valid,
   input  m3i_pkg::div_type i_data,
   output logic             i_stall,
   output logic             o_valid,
   output m3i_pkg::div_type o_data,
   input  logic             o_stall
);

   logic             valid_ff;
   m3i_pkg::div_type data_ff;
   m3i_pkg::div_type data_in;

   // The stage holds only while it carries an item that cannot move on.
   assign i_stall = valid_ff && o_stall;
   assign o_valid = valid_ff;
   assign o_data  = data_ff;

   // Shift the partial remainder left and subtract the divisor where it fits.
   always_comb begin
      logic [m3i_pkg::DET_W-1:0] rem2;
      logic [m3i_pkg::DET_W-1:0] dext;
      logic                      ge;
      data_in = i_data;
      dext    = {1'b0, i_data.dmag};
      for (int l = 0; l < m3i_pkg::LANES; l++) begin
         rem2 = {i_data.rem[l][m3i_pkg::DET_W-2:0], 1'b0};
         ge   = (rem2 >= dext);
         data_in.rem[l] = ge ? (rem2 - dext) : rem2;
         data_in.quo[l] = {i_data.quo[l][m3i_pkg::ELEM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!i_stall) begin
         valid_ff <= i_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!i_stall && i_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* design/mat3_inverse_top.sv */
// Pipelined 3x3 Q16.16 matrix inverse by the adjugate over the determinant.
//
// Takes one matrix per cycle when the output is not stalled. Eight front stages
// form the cofactors, the determinant and its magnitude; thirty-two divider
// stages then produce one quotient bit per stage for all nine elements; a last
// stage applies sign and saturation. Each element is cofactor * 2^32 / det
// truncated toward zero and saturated to the signed 32-bit range. A zero
// determinant returns all zeros with singular set. Empty slots in the pipeline
// close up under a stall, so input is taken while a finished result waits as
// long as some stage is free.
module mat3_inverse_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_a00,
   input  logic [31:0] req_a01,
   input  logic [31:0] req_a02,
   input  logic [31:0] req_a10,
   input  logic [31:0] req_a11,
   input  logic [31:0] req_a12,
   input  logic [31:0] req_a20,
   input  logic [31:0] req_a21,
   input  logic [31:0] req_a22,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_q00,
   output logic [31:0] rsp_q01,
   output logic [31:0] rsp_q02,
   output logic [31:0] rsp_q10,
   output logic [31:0] rsp_q11,
   output logic [31:0] rsp_q12,
   output logic [31:0] rsp_q20,
   output logic [31:0] rsp_q21,
   output logic [31:0] rsp_q22,
   output logic        rsp_singular
);

   localparam int L = m3i_pkg::LANES;

   // Front stage control: valid bits and hold chain.
   logic [8:1] v_ff;
   logic [8:1] st;
   logic       st_out;
   logic       out_valid_ff;

   // Stage 1: cofactor products.
   logic signed [63:0] pa_ff [L];
   logic signed [63:0] pb_ff [L];
   logic signed [31:0] a1_ff [3];
   // Stage 2: cofactors.
   logic signed [m3i_pkg::COF_W-1:0] cof_ff [L];
   logic signed [31:0]               a2_ff [3];
   // Stage 3: magnitudes and signs.
   logic [m3i_pkg::CMAG_W-1:0] cm3_ff [L];
   logic [L-1:0]               cn3_ff;
   logic [31:0]                am_ff [3];
   logic [2:0]                 an_ff;
   // Stage 4: partial products of the determinant terms.
   logic [m3i_pkg::CMAG_W-1:0] cm4_ff [L];
   logic [L-1:0]               cn4_ff;
   logic [63:0]                pl_ff [3];
   logic [63:0]                ph_ff [3];
   logic [2:0]                 tn_ff;
   // Stage 5: signed determinant terms.
   logic [m3i_pkg::CMAG_W-1:0] cm5_ff [L];
   logic [L-1:0]               cn5_ff;
   logic signed [m3i_pkg::DET_W-1:0] term_ff [3];
   // Stage 6: determinant.
   logic [m3i_pkg::CMAG_W-1:0] cm6_ff [L];
   logic [L-1:0]               cn6_ff;
   logic signed [m3i_pkg::DET_W-1:0] det_ff;
   // Stage 7: determinant magnitude.
   logic [m3i_pkg::CMAG_W-1:0] cm7_ff [L];
   logic [L-1:0]               cn7_ff;
   logic [m3i_pkg::DMAG_W-1:0] dmag_ff;
   logic                       dneg_ff;
   logic                       zero_ff;
   // Stage 8: divider setup.
   m3i_pkg::div_type div0_ff;

   // Divider chain.
   logic             dv [0:m3i_pkg::DIV_STEPS];
   m3i_pkg::div_type dd [0:m3i_pkg::DIV_STEPS];
   logic             dst [0:m3i_pkg::DIV_STEPS];

   // Output stage.
   logic [L-1:0][31:0] res_ff;
   logic               sing_ff;
   logic [L-1:0][31:0] res_in;

   // A stage holds when it is full and the stage after it holds.
   assign st_out = out_valid_ff && rsp_stall;
   assign st[8]  = v_ff[8] && dst[0];
   always_comb begin
      for (int k = 1; k < 8; k++) begin
         st[k] = v_ff[k] && st[k+1];
      end
   end
   assign req_stall = st[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (!st[1]) v_ff[1] <= req_valid;
         for (int k = 2; k <= 8; k++) begin
            if (!st[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // Stage 1: the eighteen 32x32 products of the cofactors.
   always_ff @(posedge clock) begin
      if (!st[1] && req_valid) begin
         pa_ff[0] <= $signed(req_a11) * $signed(req_a22);
         pb_ff[0] <= $signed(req_a12) * $signed(req_a21);
         pa_ff[1] <= $signed(req_a12) * $signed(req_a20);
         pb_ff[1] <= $signed(req_a10) * $signed(req_a22);
         pa_ff[2] <= $signed(req_a10) * $signed(req_a21);
         pb_ff[2] <= $signed(req_a11) * $signed(req_a20);
         pa_ff[3] <= $signed(req_a02) * $signed(req_a21);
         pb_ff[3] <= $signed(req_a01) * $signed(req_a22);
         pa_ff[4] <= $signed(req_a00) * $signed(req_a22);
         pb_ff[4] <= $signed(req_a02) * $signed(req_a20);
         pa_ff[5] <= $signed(req_a01) * $signed(req_a20);
         pb_ff[5] <= $signed(req_a00) * $signed(req_a21);
         pa_ff[6] <= $signed(req_a01) * $signed(req_a12);
         pb_ff[6] <= $signed(req_a02) * $signed(req_a11);
         pa_ff[7] <= $signed(req_a02) * $signed(req_a10);
         pb_ff[7] <= $signed(req_a00) * $signed(req_a12);
         pa_ff[8] <= $signed(req_a00) * $signed(req_a11);
         pb_ff[8] <= $signed(req_a01) * $signed(req_a10);
         a1_ff[0] <= $signed(req_a00);
         a1_ff[1] <= $signed(req_a01);
         a1_ff[2] <= $signed(req_a02);
      end
   end

   // Stage 2: cofactor differences, exact in 65 bits.
   always_ff @(posedge clock) begin
      if (!st[2] && v_ff[1]) begin
         for (int l = 0; l < L; l++) begin
            cof_ff[l] <= {pa_ff[l][63], pa_ff[l]} - {pb_ff[l][63], pb_ff[l]};
         end
         a2_ff <= a1_ff;
      end
   end

   // Stage 3: split into magnitude and sign.
   always_ff @(posedge clock) begin
      logic [m3i_pkg::COF_W-1:0] nc;
      if (!st[3] && v_ff[2]) begin
         for (int l = 0; l < L; l++) begin
            nc         = -cof_ff[l];
            cn3_ff[l] <= cof_ff[l][m3i_pkg::COF_W-1];
            cm3_ff[l] <= cof_ff[l][m3i_pkg::COF_W-1] ? nc[m3i_pkg::CMAG_W-1:0]
                                                     : cof_ff[l][m3i_pkg::CMAG_W-1:0];
         end
         for (int j = 0; j < 3; j++) begin
            an_ff[j] <= a2_ff[j][31];
            am_ff[j] <= a2_ff[j][31] ? 32'(-a2_ff[j]) : a2_ff[j];
         end
      end
   end

   // Stage 4: first-row element times cofactor, as two 32x32 partial products.
   always_ff @(posedge clock) begin
      if (!st[4] && v_ff[3]) begin
         cm4_ff <= cm3_ff;
         cn4_ff <= cn3_ff;
         for (int j = 0; j < 3; j++) begin
            pl_ff[j] <= 64'(cm3_ff[j][31:0])  * 64'(am_ff[j]);
            ph_ff[j] <= 64'(cm3_ff[j][63:32]) * 64'(am_ff[j]);
            tn_ff[j] <= an_ff[j] ^ cn3_ff[j];
         end
      end
   end

   // Stage 5: join the partial products and apply the term sign.
   always_ff @(posedge clock) begin
      logic [m3i_pkg::DET_W-1:0] mag;
      if (!st[5] && v_ff[4]) begin
         cm5_ff <= cm4_ff;
         cn5_ff <= cn4_ff;
         for (int j = 0; j < 3; j++) begin
            mag         = {33'b0, pl_ff[j]} + {1'b0, ph_ff[j], 32'b0};
            term_ff[j] <= tn_ff[j] ? -$signed(mag) : $signed(mag);
         end
      end
   end

   // Stage 6: determinant as the sum of the three terms.
   always_ff @(posedge clock) begin
      if (!st[6] && v_ff[5]) begin
         cm6_ff <= cm5_ff;
         cn6_ff <= cn5_ff;
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
      end
   end

   // Stage 7: determinant magnitude, sign and zero test.
   always_ff @(posedge clock) begin
      logic [m3i_pkg::DET_W-1:0] nd;
      if (!st[7] && v_ff[6]) begin
         nd       = -det_ff;
         cm7_ff  <= cm6_ff;
         cn7_ff  <= cn6_ff;
         dneg_ff <= det_ff[m3i_pkg::DET_W-1];
         dmag_ff <= det_ff[m3i_pkg::DET_W-1] ? nd[m3i_pkg::DMAG_W-1:0]
                                             : det_ff[m3i_pkg::DMAG_W-1:0];
         zero_ff <= (det_ff == '0);
      end
   end

   // Stage 8: load the dividers; a cofactor at least as large as the
   // determinant gives a quotient of 2^32 or more and saturates.
   always_ff @(posedge clock) begin
      if (!st[8] && v_ff[7]) begin
         for (int l = 0; l < L; l++) begin
            div0_ff.rem[l] <= {33'b0, cm7_ff[l]};
            div0_ff.quo[l] <= '0;
            div0_ff.neg[l] <= cn7_ff[l] ^ dneg_ff;
            div0_ff.ovf[l] <= ({32'b0, cm7_ff[l]} >= dmag_ff);
         end
         div0_ff.dmag <= dmag_ff;
         div0_ff.zero <= zero_ff;
      end
   end

   assign dv[0] = v_ff[8];
   assign dd[0] = div0_ff;
   assign dst[m3i_pkg::DIV_STEPS] = st_out;

   // One quotient bit per stage.
   for (genvar i = 0; i < m3i_pkg::DIV_STEPS; i++) begin : g_div
      m3i_div_stage u_step (
         .clock   (clock),
         .reset   (reset),
         .i_valid (dv[i]),
         .i_data  (dd[i]),
         .i_stall (dst[i]),
         .o_valid (dv[i+1]),
         .o_data  (dd[i+1]),
         .o_stall (dst[i+1])
      );
   end

   // Sign, saturation and the singular case; element (r, c) takes lane c*3+r.
   always_comb begin
      m3i_pkg::div_type d;
      logic [31:0]      qv;
      int               lane;
      d = dd[m3i_pkg::DIV_STEPS];
      for (int k = 0; k < L; k++) begin
         lane = (k % 3) * 3 + (k / 3);
         qv   = d.quo[lane];
         if (d.zero) begin
            res_in[k] = '0;
         end else if (d.neg[lane]) begin
            res_in[k] = (d.ovf[lane] || qv > m3i_pkg::SAT_NEG) ? m3i_pkg::SAT_NEG : -qv;
         end else begin
            res_in[k] = (d.ovf[lane] || qv > m3i_pkg::SAT_POS) ? m3i_pkg::SAT_POS : qv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!st_out) begin
         out_valid_ff <= dv[m3i_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (!st_out && dv[m3i_pkg::DIV_STEPS]) begin
         res_ff  <= res_in;
         sing_ff <= dd[m3i_pkg::DIV_STEPS].zero;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_q00      = res_ff[0];
   assign rsp_q01      = res_ff[1];
   assign rsp_q02      = res_ff[2];
   assign rsp_q10      = res_ff[3];
   assign rsp_q11      = res_ff[4];
   assign rsp_q12      = res_ff[5];
   assign rsp_q20      = res_ff[6];
   assign rsp_q21      = res_ff[7];
   assign rsp_q22      = res_ff[8];
   assign rsp_singular = sing_ff;

   // A singular result carries an all-zero matrix.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> (res_ff == '0))
      else $error("singular result with nonzero elements");

   // The input side only stalls when a result is being held at the output.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output is free");

   // Nothing leaves the pipeline right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

/* tb/mat3_inverse_top_tb.sv */
// Self-checking testbench for the pipelined 3x3 Q16.16 matrix inverse.
`timescale 1ns / 100ps

module mat3_inverse_top_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 60;

   typedef logic [8:0][31:0] mat_type;

   typedef struct {
      mat_type q;
      logic    singular;
   } inverse_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mat_type     req_m = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mat_type     rsp_m;
   logic        rsp_singular;

   mat_type     matrix_queue[$];
   inverse_type inverse_queue[$];
   logic        took = 1'b0;
   logic        calm = 1'b0;
   logic        failed = 1'b0;
   int          gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   int          accepted = 0;
   int          quiet = 0;

   mat3_inverse_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a00(req_m[0]), .req_a01(req_m[1]), .req_a02(req_m[2]),
      .req_a10(req_m[3]), .req_a11(req_m[4]), .req_a12(req_m[5]),
      .req_a20(req_m[6]), .req_a21(req_m[7]), .req_a22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_q00(rsp_m[0]), .rsp_q01(rsp_m[1]), .rsp_q02(rsp_m[2]),
      .rsp_q10(rsp_m[3]), .rsp_q11(rsp_m[4]), .rsp_q12(rsp_m[5]),
      .rsp_q20(rsp_m[6]), .rsp_q21(rsp_m[7]), .rsp_q22(rsp_m[8]),
      .rsp_singular(rsp_singular)
   );

   // Exact adjugate over determinant, truncated toward zero and saturated.
   function automatic inverse_type invert(mat_type m);
      logic signed [199:0] a[9];
      logic signed [199:0] c[9];
      logic signed [199:0] det;
      logic signed [199:0] quo;
      inverse_type r;
      for (int k = 0; k < 9; k++) a[k] = $signed(m[k]);
      c[0] = a[4] * a[8] - a[5] * a[7];
      c[1] = a[5] * a[6] - a[3] * a[8];
      c[2] = a[3] * a[7] - a[4] * a[6];
      c[3] = a[2] * a[7] - a[1] * a[8];
      c[4] = a[0] * a[8] - a[2] * a[6];
      c[5] = a[1] * a[6] - a[0] * a[7];
      c[6] = a[1] * a[5] - a[2] * a[4];
      c[7] = a[2] * a[3] - a[0] * a[5];
      c[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * c[0] + a[1] * c[1] + a[2] * c[2];
      r.singular = (det == 0);
      for (int k = 0; k < 9; k++) begin
         if (r.singular) begin
            r.q[k] = '0;
         end else begin
            // Element (row, col) takes the cofactor of (col, row).
            quo = (c[(k % 3) * 3 + k / 3] <<< 32) / det;
            if (quo > 200'sd2147483647) r.q[k] = m3i_pkg::SAT_POS;
            else if (quo < -200'sd2147483648) r.q[k] = m3i_pkg::SAT_NEG;
            else r.q[k] = quo[31:0];
         end
      end
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         2: return $urandom_range(0, 32'h0000_0100) - 32'h0000_0080;
         default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      endcase
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // Stimulus: directed corner matrices, then random ones.
   initial begin
      mat_type m;
      logic [31:0] one;
      one = 32'h0001_0000;
      matrix_queue.push_back({one, 32'd0, 32'd0, 32'd0, one, 32'd0, 32'd0, 32'd0, one});
      matrix_queue.push_back('0);
      matrix_queue.push_back({9{32'h7FFF_FFFF}});
      matrix_queue.push_back({9{32'h8000_0000}});
      matrix_queue.push_back({9{32'hFFFF_FFFF}});
      matrix_queue.push_back({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
      matrix_queue.push_back({-one, 32'd0, 32'd0, 32'd0, -one, 32'd0, 32'd0, 32'd0, -one});
      matrix_queue.push_back({32'd0, one, 32'd0, 32'd0, 32'd0, one, one, 32'd0, 32'd0});
      matrix_queue.push_back({32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0,
                              32'd0, 32'd0, 32'h7FFF_FFFF});
      matrix_queue.push_back({32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'd0,
                              32'd0, 32'd0, 32'h8000_0000});
      matrix_queue.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                              32'h8000_0000});
      // Rank two: one row is the sum of the other two.
      matrix_queue.push_back({one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one,
                              5 * one, 7 * one, 9 * one});
      matrix_queue.push_back({2 * one, one, 32'd0, one, 2 * one, one, 32'd0, one, 2 * one});
      matrix_queue.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                              32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC,
                              32'h00FF_00FF, 32'hFF00_FF00, 32'h1234_5678});
      for (int n = 0; n < 500; n++) begin
         for (int k = 0; k < 9; k++) m[k] = rand_word();
         // Now and then make the matrix singular by repeating a row.
         if ($urandom_range(0, 9) == 0) begin
            m[8] = m[5]; m[7] = m[4]; m[6] = m[3];
         end
         matrix_queue.push_back(m);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (matrix_queue.size() == 0 && !req_valid);
      wait (inverse_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && inverse_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Sender: offers items at the falling edge, with random gaps.
   always @(negedge clock) begin
      calm = (matrix_queue.size() < 100);
      if (!reset && (!req_valid || took)) begin
         if (gap > 0) begin
            gap = gap - 1;
            req_valid <= 1'b0;
         end else if (matrix_queue.size() > 0) begin
            req_m <= matrix_queue.pop_front();
            req_valid <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts and one long hold-off to fill the pipeline.
   always @(negedge clock) begin
      if (!hold_done && accepted >= 100) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on each accepted item and check each accepted result.
   always @(posedge clock) begin
      inverse_type want;
      took = !reset && req_valid && !req_stall;
      if (took) begin
         inverse_queue.push_back(invert(req_m));
         accepted = accepted + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inverse_queue.size() == 0) begin
            $display("%0t: result with no matrix pending: q=%h singular=%b",
                     $time, rsp_m, rsp_singular);
            failed = 1'b1;
         end else begin
            want = inverse_queue.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (rsp_m[k] !== want.q[k]) begin
                  $display("%0t: q%0d%0d expected %h actual %h",
                           $time, k / 3, k % 3, want.q[k], rsp_m[k]);
                  failed = 1'b1;
               end
            end
            if (rsp_singular !== want.singular) begin
               $display("%0t: singular expected %b actual %b",
                        $time, want.singular, rsp_singular);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog on cycles with no traffic on either channel.
   always @(posedge clock) begin
      if (took || (rsp_valid && !rsp_stall) || reset) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule

/* sim.f */
design/m3i_pkg.sv
design/m3i_div_stage.sv
design/mat3_inverse_top.sv
tb/mat3_inverse_top_tb.sv
